/* rtl/dse_pkg.sv */
package dse_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned FIELD_W = 7;
    localparam int unsigned DAYS_W  = 16;
    localparam int unsigned SECS_W  = 33;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_P     = 8'h70;

    localparam logic [FIELD_W-1:0] MONTH_MAX  = 7'd12;
    localparam logic [FIELD_W-1:0] DAY_MAX    = 7'd31;
    localparam logic [FIELD_W-1:0] MINUTE_MAX = 7'd59;
    localparam logic [FIELD_W-1:0] HOUR_ROLL  = 7'd24;
    localparam logic [FIELD_W-1:0] HOUR_MAX   = 7'd23;
    localparam logic [FIELD_W-1:0] PM_OFFSET  = 7'd12;

    // years counted from 2000; 2000 - 1970 = 30, leap base (1999)/4 = 499 .. minus 492
    localparam logic [7:0]  YEAR_OFFSET = 8'd30;
    localparam logic [10:0] YEAR_M1     = 11'd1999;
    localparam logic [9:0]  LEAP_BASE   = 10'd492;
    localparam logic [8:0]  DAYS_YEAR   = 9'd365;

    localparam logic [16:0] SECS_DAY    = 17'd86400;
    localparam logic [11:0] SECS_HOUR   = 12'd3600;
    localparam logic [5:0]  SECS_MINUTE = 6'd60;

    typedef enum logic [2:0] {
        PAIR_MONTH  = 3'd0,
        PAIR_DAY    = 3'd1,
        PAIR_HOUR   = 3'd2,
        PAIR_MINUTE = 3'd3,
        PAIR_YEAR   = 3'd4,
        PAIR_PM     = 3'd5,
        PAIR_DONE   = 3'd6
    } pair_t;

    typedef struct packed {
        pair_t              pair_index;
        logic               half_pair;
        logic [FIELD_W-1:0] tens_value;
        logic [FIELD_W-1:0] month_value;
        logic [FIELD_W-1:0] day_value;
        logic [FIELD_W-1:0] hour_value;
        logic [FIELD_W-1:0] minute_value;
        logic [FIELD_W-1:0] year_value;
        logic               year_seen;
        logic               pm_seen;
        logic               parse_failed;
    } parse_state_t;

    typedef struct packed {
        logic               failed;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] year;
        logic               pm;
    } snap_t;

    typedef struct packed {
        logic              failed;
        logic [DAYS_W-1:0] days;
        logic [4:0]        hour;
        logic [5:0]        minute;
    } calc_t;

    function automatic logic [8:0] days_before_month(input logic [FIELD_W-1:0] month);
        logic [8:0] d;
        case (month)
            7'd1:    d = 9'd0;
            7'd2:    d = 9'd31;
            7'd3:    d = 9'd59;
            7'd4:    d = 9'd90;
            7'd5:    d = 9'd120;
            7'd6:    d = 9'd151;
            7'd7:    d = 9'd181;
            7'd8:    d = 9'd212;
            7'd9:    d = 9'd243;
            7'd10:   d = 9'd273;
            7'd11:   d = 9'd304;
            7'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* rtl/dse_if.sv */
interface dse_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

interface dse_result_if;
    logic        valid;
    logic        ready;
    logic [32:0] epoch_seconds;
    logic        error;

    modport source (output valid, output epoch_seconds, output error, input ready);
    modport sink   (input valid, input epoch_seconds, input error, output ready);
endinterface

interface dse_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] default_year;

    modport source (output valid, output default_year, input ready);
    modport sink   (input valid, input default_year, output ready);
endinterface

/* rtl/dse_parse.sv */
module dse_parse (
    input  logic                   clk,
    input  logic                   rst_n,
    dse_char_if.sink               chars,
    input  logic [6:0]             default_year,
    input  logic                   snap_take,
    output logic                   snap_valid,
    output dse_pkg::snap_t         snap
);
    import dse_pkg::*;

    parse_state_t st_reg;
    parse_state_t st_next;
    logic         snap_valid_reg;
    snap_t        snap_reg;
    snap_t        snap_next;
    logic         stage_take;
    logic         accept;

    assign stage_take   = !snap_valid_reg || snap_take;
    assign chars.ready  = stage_take;
    assign accept       = chars.valid && stage_take;
    assign snap_valid   = snap_valid_reg;
    assign snap         = snap_reg;

    always_comb
    begin
        logic               tens_ok;
        logic               digit_ok;
        logic [FIELD_W-1:0] v;
        logic [7:0]         off;
        logic               short;

        off      = chars.text_char - CH_ZERO;
        tens_ok  = chars.text_char >= CH_ZERO && chars.text_char <= CH_COLON;
        digit_ok = chars.text_char >= CH_ZERO && chars.text_char <= CH_NINE;
        v        = st_reg.tens_value + FIELD_W'(off[3:0]);
        st_next  = st_reg;

        if (chars.text_char == CH_NUL)
        begin
            if (!st_reg.parse_failed && st_reg.pair_index != PAIR_DONE)
            begin
                if (st_reg.pair_index inside {PAIR_MONTH, PAIR_DAY, PAIR_HOUR, PAIR_MINUTE})
                    st_next.parse_failed = 1'b1;
                else
                    st_next.pair_index = PAIR_DONE;
            end
        end
        else if (!st_reg.parse_failed && st_reg.pair_index != PAIR_DONE)
        begin
            if (st_reg.pair_index == PAIR_PM)
            begin
                st_next.pm_seen    = chars.text_char == CH_P;
                st_next.pair_index = PAIR_DONE;
            end
            else if (!st_reg.half_pair)
            begin
                if (tens_ok)
                begin
                    st_next.tens_value = FIELD_W'(off[3:0] * 4'd10);
                    st_next.half_pair  = 1'b1;
                end
                else if (st_reg.pair_index == PAIR_YEAR)
                begin
                    st_next.pm_seen    = chars.text_char == CH_P;
                    st_next.pair_index = PAIR_DONE;
                end
                else
                    st_next.parse_failed = 1'b1;
            end
            else
            begin
                st_next.half_pair = 1'b0;
                if (!digit_ok)
                begin
                    if (st_reg.pair_index == PAIR_YEAR)
                        st_next.pair_index = PAIR_DONE;
                    else
                        st_next.parse_failed = 1'b1;
                end
                else
                begin
                    unique case (st_reg.pair_index)
                        PAIR_MONTH:
                        begin
                            st_next.month_value = v;
                            if (v == '0 || v > MONTH_MAX)
                                st_next.parse_failed = 1'b1;
                        end
                        PAIR_DAY:
                        begin
                            st_next.day_value = v;
                            if (v == '0 || v > DAY_MAX)
                                st_next.parse_failed = 1'b1;
                        end
                        PAIR_HOUR:
                            st_next.hour_value = v;
                        PAIR_MINUTE:
                        begin
                            st_next.minute_value = v;
                            if (v > MINUTE_MAX)
                                st_next.parse_failed = 1'b1;
                        end
                        default:
                        begin
                            st_next.year_value = v;
                            st_next.year_seen  = 1'b1;
                        end
                    endcase
                    st_next.pair_index = pair_t'(st_reg.pair_index + 3'd1);
                end
            end
        end

        short = st_next.pair_index inside {PAIR_MONTH, PAIR_DAY, PAIR_HOUR, PAIR_MINUTE};
        snap_next.failed = st_next.parse_failed || short;
        snap_next.month  = st_next.month_value;
        snap_next.day    = st_next.day_value;
        snap_next.hour   = st_next.hour_value;
        snap_next.minute = st_next.minute_value;
        snap_next.year   = st_next.year_seen ? st_next.year_value : default_year;
        snap_next.pm     = st_next.pm_seen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                st_reg <= chars.last_char ? parse_state_t'('0) : st_next;
            if (stage_take)
                snap_valid_reg <= accept && chars.last_char;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_take)
            snap_reg <= snap_next;
    end

endmodule

/* rtl/dse_calc.sv */
module dse_calc (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           snap_valid,
    input  dse_pkg::snap_t snap,
    output logic           snap_take,
    input  logic           calc_take,
    output logic           calc_valid,
    output dse_pkg::calc_t calc
);
    import dse_pkg::*;

    logic  calc_valid_reg;
    calc_t calc_reg;
    calc_t calc_next;

    assign snap_take  = !calc_valid_reg || calc_take;
    assign calc_valid = calc_valid_reg;
    assign calc       = calc_reg;

    always_comb
    begin
        logic [FIELD_W-1:0] h;
        logic [5:0]         d;
        logic [11:0]        quarter;
        logic [16:0]        days;
        logic               leap;

        h = snap.hour;
        d = snap.day[5:0];
        if (snap.hour == HOUR_ROLL)
        begin
            h = '0;
            d = snap.day[5:0] + 6'd1;
        end
        if (snap.pm)
            h = h + PM_OFFSET;

        quarter = (12'(YEAR_M1) + 12'(snap.year)) >> 2;
        leap    = snap.year[1:0] == 2'b00 && snap.month >= 7'd3;
        days    = 17'((8'(snap.year) + YEAR_OFFSET) * DAYS_YEAR)
                + 17'(quarter) - 17'(LEAP_BASE)
                + 17'(leap)
                + 17'(days_before_month(snap.month))
                + 17'(d) - 17'd1;

        calc_next.failed = snap.failed || h > HOUR_MAX;
        calc_next.days   = days[DAYS_W-1:0];
        calc_next.hour   = h[4:0];
        calc_next.minute = snap.minute[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            calc_valid_reg <= 1'b0;
        else if (snap_take)
            calc_valid_reg <= snap_valid;
    end

    always_ff @(posedge clk)
    begin
        if (snap_take)
            calc_reg <= calc_next;
    end

endmodule

/* rtl/dse_sum.sv */
module dse_sum (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           calc_valid,
    input  dse_pkg::calc_t calc,
    output logic           calc_take,
    dse_result_if.source   result
);
    import dse_pkg::*;

    logic              valid_reg;
    logic [SECS_W-1:0] secs_reg;
    logic [SECS_W-1:0] secs_next;
    logic              error_reg;

    assign calc_take            = !valid_reg || result.ready;
    assign result.valid         = valid_reg;
    assign result.epoch_seconds = secs_reg;
    assign result.error         = error_reg;

    always_comb
    begin
        secs_next = SECS_W'(calc.days * SECS_DAY)
                  + SECS_W'(calc.hour * SECS_HOUR)
                  + SECS_W'(calc.minute * SECS_MINUTE);
        if (calc.failed)
            secs_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (calc_take)
            valid_reg <= calc_valid;
    end

    always_ff @(posedge clk)
    begin
        if (calc_take)
        begin
            secs_reg  <= secs_next;
            error_reg <= calc.failed;
        end
    end

endmodule

/* rtl/date_string_to_epoch_seconds.sv */
// Date string to seconds since 1970.
// chars:  one character item per handshake (text_char, last_char). The string
//         MMDDhhmm[yy][p] is parsed as it streams; the item with last_char set
//         closes the string.
// result: one item per closed string: epoch_seconds and error (seconds are 0
//         on error). Nothing comes out for other characters.
// cfg:    default_year, the two-digit year used when the string has none.
//         Always ready; write only while no string is in flight.
// Throughput: one character item per cycle while chars.ready is high.
// The result passes through the parse output register, which loads at the
// edge that accepts the last character, then the calendar stage register,
// then the seconds output register.
// Stall: each stage holds while its successor is full; chars.ready drops
// only when the parse output register is full and cannot move on.
// Reset: parse state cleared, pipeline empty, default_year = 0.
module date_string_to_epoch_seconds (
    input  logic          clk,
    input  logic          rst_n,
    dse_char_if.sink      chars,
    dse_result_if.source  result,
    dse_cfg_if.sink       cfg
);
    import dse_pkg::*;

    logic [FIELD_W-1:0] default_year_reg;
    logic               snap_valid;
    logic               snap_take;
    snap_t              snap;
    logic               calc_valid;
    logic               calc_take;
    calc_t              calc;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            default_year_reg <= '0;
        else if (cfg.valid)
            default_year_reg <= cfg.default_year;
    end

    dse_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .chars        (chars),
        .default_year (default_year_reg),
        .snap_take    (snap_take),
        .snap_valid   (snap_valid),
        .snap         (snap)
    );

    dse_calc u_calc (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_take  (snap_take),
        .calc_take  (calc_take),
        .calc_valid (calc_valid),
        .calc       (calc)
    );

    dse_sum u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .calc_valid (calc_valid),
        .calc       (calc),
        .calc_take  (calc_take),
        .result     (result)
    );

endmodule
